### design/fqss_pkg.sv
`timescale 1ns / 1ps
package fqss_pkg;

    localparam int DEPTH  = 16;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int ST_W   = 3;

    // stream payload widths, rounded up to whole bytes
    localparam int IN_DATA_W  = ((3 * DATA_W + CNT_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((DATA_W + PTR_W + CNT_W + 1 + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_ENQ  = 3'd0;
    localparam logic [OP_W-1:0] OP_DEQ  = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
    localparam logic [OP_W-1:0] OP_SRCH = 3'd3;
    localparam logic [OP_W-1:0] OP_CLR  = 3'd4;
    localparam logic [OP_W-1:0] OP_REM  = 3'd5;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_TOO_MANY  = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic latch;     // capture request fields
        logic exec;      // run the single-step part of the operation
        logic sweep;     // walk the stored entries
        logic load_out;  // load the result register
    } t_cmd;

    typedef struct packed {
        logic is_sweep;
        logic sweep_done;
    } t_sts;

    // ring pointer advance; n never exceeds DEPTH
    function automatic logic [PTR_W-1:0] ring_add(logic [PTR_W-1:0] p, logic [CNT_W-1:0] n);
        logic [CNT_W:0] s;
        s = {{(CNT_W + 1 - PTR_W){1'b0}}, p} + {1'b0, n};
        if (s >= (CNT_W + 1)'(DEPTH)) begin
            s = s - (CNT_W + 1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

### design/fqss_ram.sv
`timescale 1ns / 1ps
module fqss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [WIDTH-1:0]           i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [WIDTH-1:0]           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds until the next read
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/fqss_ctrl.sv
`timescale 1ns / 1ps
module fqss_ctrl
    import fqss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_SWEEP  = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   out_free;

    assign out_free   = !r_out_vld || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state        = r_state;
        n_out_vld      = r_out_vld;
        o_cmd          = '0;
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.is_sweep ? S_SWEEP : S_RESULT;
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                // wait for the previous result to drain
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

### design/fqss_dp.sv
`timescale 1ns / 1ps
module fqss_dp
    import fqss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [OP_W-1:0]       i_op,
    input  logic [IN_DATA_W-1:0]  i_data,
    output logic [ST_W-1:0]       o_status,
    output logic [OUT_DATA_W-1:0] o_data
);

    // queue state
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;

    // captured request
    logic [OP_W-1:0]   r_op, n_op;
    logic [DATA_W-1:0] r_item, n_item;
    logic [DATA_W-1:0] r_factor, n_factor;
    logic [DATA_W-1:0] r_key, n_key;
    logic [CNT_W-1:0]  r_nrem, n_nrem;
    logic [ST_W-1:0]   r_status, n_status;

    // sweep pipeline: issue read, data back, product write
    logic [CNT_W-1:0]  r_rd_idx, n_rd_idx;
    logic [PTR_W-1:0]  r_sw_ptr, n_sw_ptr;
    logic              r_rd_vld, n_rd_vld;
    logic [PTR_W-1:0]  r_rd_slot, n_rd_slot;
    logic [PTR_W-1:0]  r_rd_off, n_rd_off;
    logic              r_wr_vld, n_wr_vld;
    logic [PTR_W-1:0]  r_wr_slot, n_wr_slot;
    logic [DATA_W-1:0] r_prod, n_prod;
    logic              r_found, n_found;
    logic [PTR_W-1:0]  r_index, n_index;

    // result register
    logic [ST_W-1:0]   r_o_status, n_o_status;
    logic [DATA_W-1:0] r_o_value, n_o_value;
    logic [PTR_W-1:0]  r_o_index, n_o_index;
    logic [CNT_W-1:0]  r_o_count, n_o_count;
    logic              r_o_empty, n_o_empty;

    logic              ram_wr_en;
    logic [PTR_W-1:0]  ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [PTR_W-1:0]  ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;
    logic              issue;
    logic              full;

    fqss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign full  = (r_count == CNT_W'(DEPTH));
    assign issue = i_cmd.sweep && (r_rd_idx != r_count) && !r_found;

    assign o_sts.is_sweep   = (r_op == OP_MUL) || (r_op == OP_SRCH);
    assign o_sts.sweep_done = ((r_rd_idx == r_count) || r_found) && !r_rd_vld && !r_wr_vld;

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_op       = r_op;
        n_item     = r_item;
        n_factor   = r_factor;
        n_key      = r_key;
        n_nrem     = r_nrem;
        n_status   = r_status;
        n_rd_idx   = r_rd_idx;
        n_sw_ptr   = r_sw_ptr;
        n_rd_vld   = 1'b0;
        n_rd_slot  = r_rd_slot;
        n_rd_off   = r_rd_off;
        n_wr_vld   = r_rd_vld && (r_op == OP_MUL);
        n_wr_slot  = r_rd_slot;
        n_prod     = ram_rd_data * r_factor;
        n_found    = r_found;
        n_index    = r_index;
        n_o_status = r_o_status;
        n_o_value  = r_o_value;
        n_o_index  = r_o_index;
        n_o_count  = r_o_count;
        n_o_empty  = r_o_empty;

        ram_wr_en   = 1'b0;
        ram_wr_addr = r_wr_slot;
        ram_wr_data = r_prod;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_sw_ptr;

        if (i_cmd.latch) begin
            n_op     = i_op;
            n_item   = i_data[DATA_W-1:0];
            n_factor = i_data[2*DATA_W-1:DATA_W];
            n_key    = i_data[3*DATA_W-1:2*DATA_W];
            n_nrem   = i_data[3*DATA_W+CNT_W-1:3*DATA_W];
            n_rd_idx = '0;
            n_sw_ptr = r_head;
            n_found  = 1'b0;
        end

        if (i_cmd.exec) begin
            n_status = ST_OK;
            unique case (r_op)
                OP_ENQ: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = r_tail;
                        ram_wr_data = r_item;
                        n_tail      = ring_add(r_tail, CNT_W'(1));
                        n_count     = r_count + CNT_W'(1);
                    end
                end
                OP_DEQ: begin
                    if (r_count == '0) begin
                        n_status = ST_UNDERFLOW;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = r_head;
                        n_head      = ring_add(r_head, CNT_W'(1));
                        n_count     = r_count - CNT_W'(1);
                    end
                end
                OP_SRCH: begin
                    n_status = ST_NOT_FOUND;
                end
                OP_CLR: begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                end
                OP_REM: begin
                    if (r_nrem > r_count) begin
                        n_status = ST_TOO_MANY;
                    end else begin
                        n_head  = ring_add(r_head, r_nrem);
                        n_count = r_count - r_nrem;
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end

        if (issue) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = r_sw_ptr;
            n_rd_vld    = 1'b1;
            n_rd_slot   = r_sw_ptr;
            n_rd_off    = r_rd_idx[PTR_W-1:0];
            n_sw_ptr    = ring_add(r_sw_ptr, CNT_W'(1));
            n_rd_idx    = r_rd_idx + CNT_W'(1);
        end

        // reads issued past a match are dropped here
        if (r_rd_vld && (r_op == OP_SRCH) && !r_found && (ram_rd_data == r_key)) begin
            n_found = 1'b1;
            n_index = r_rd_off;
        end

        if (r_wr_vld) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_wr_slot;
            ram_wr_data = r_prod;
        end

        if (i_cmd.load_out) begin
            n_o_status = ((r_op == OP_SRCH) && r_found) ? ST_OK : r_status;
            n_o_value  = ((r_op == OP_DEQ) && (r_status == ST_OK)) ? ram_rd_data : '0;
            n_o_index  = r_found ? r_index : '0;
            n_o_count  = r_count;
            n_o_empty  = (r_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_wr_vld <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
            r_wr_vld <= n_wr_vld;
            r_found  <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_item     <= n_item;
        r_factor   <= n_factor;
        r_key      <= n_key;
        r_nrem     <= n_nrem;
        r_status   <= n_status;
        r_rd_idx   <= n_rd_idx;
        r_sw_ptr   <= n_sw_ptr;
        r_rd_slot  <= n_rd_slot;
        r_rd_off   <= n_rd_off;
        r_wr_slot  <= n_wr_slot;
        r_prod     <= n_prod;
        r_index    <= n_index;
        r_o_status <= n_o_status;
        r_o_value  <= n_o_value;
        r_o_index  <= n_o_index;
        r_o_count  <= n_o_count;
        r_o_empty  <= n_o_empty;
    end

    assign o_status = r_o_status;
    assign o_data   = {{(OUT_DATA_W - DATA_W - PTR_W - CNT_W - 1){1'b0}},
                       r_o_empty, r_o_count, r_o_index, r_o_value};

endmodule

### design/fifo_queue_with_scale_and_search_top.sv
`timescale 1ns / 1ps
// Bounded queue of 32-bit signed words (DEPTH entries) with scale and search.
// Request channel s_axis: tuser carries the operation (enqueue, dequeue,
// multiply all, search, clear, remove n); tdata carries the operands.
// Result channel m_axis: one result per request; tuser carries the status,
// tdata the dequeued word, found index, count after the operation and empty flag.
// One request is worked on at a time. A request is taken in the idle state;
// for enqueue, dequeue, clear, remove n and unused codes, it passes through the
// execute and result states before its result is loaded and m_axis_tvalid rises.
// Multiply all and search walk the stored entries through the one read port of
// the entry RAM, one entry per cycle, in a sweep state between execute and
// result; search stops early at a match.
// The next request is accepted the cycle after its predecessor's result is
// loaded, even if that result is still waiting on m_axis_tready.
// If the receiver stalls, the result holds in the output register and a
// finished request waits for it to drain before its own result is loaded.
// Reset (i_rst_n low, synchronous) empties the queue; entry contents are not
// cleared and need no clearing pass.
module fifo_queue_with_scale_and_search_top
    import fqss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // item_value[31:0], factor[63:32], search_value[95:64], remove_count[100:96]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // operation[2:0]
    input  logic [OP_W-1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_value[31:0], found_index[35:32], item_count[40:36], is_empty[41]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [ST_W-1:0]       m_axis_tuser
);

    t_cmd cmd;
    t_sts sts;

    fqss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fqss_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_op     (s_axis_tuser),
        .i_data   (s_axis_tdata),
        .o_status (m_axis_tuser),
        .o_data   (m_axis_tdata)
    );

endmodule
